>>> src/spft_pkg.sv
// Shared types, codes and constants of the servo position feedback tracker.
`default_nettype none
package spft_pkg;

   // Operation codes carried by a request transfer.
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;

   // Response status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_MOTOR = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOL_FIRST  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOL_SECOND = 4'd1;

   // PWM compare span, floor and the tolerance after reset.
   localparam int unsigned PWM_SPAN  = 350;
   localparam int unsigned PWM_FLOOR = 10;
   localparam logic [7:0]  TOL_RESET = 8'd3;

   // Field widths of the channels.
   localparam int unsigned ANGLE_W   = 8;
   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned COMPARE_W = 9;
   localparam int unsigned FLAGS_W   = 2;
   localparam int unsigned MEAN_W    = 16;

   // Outcome of the end-of-frame update for one motor.
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               moving;
   } frame_type;

   // True when two angles differ by more than the tolerance.
   function automatic logic exceeds(logic [ANGLE_W-1:0] a, logic [ANGLE_W-1:0] b,
                                    logic [ANGLE_W-1:0] tol);
      logic [ANGLE_W-1:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff > tol;
   endfunction

endpackage
`default_nettype wire

>>> src/spft_req_if.sv
// Request channel of the tracker: operation, motor, target and converter sample.
`default_nettype none
interface spft_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     operation;
   logic [7:0]                     motor_id;
   logic [spft_pkg::ANGLE_W-1:0]   target_angle;
   logic [spft_pkg::SAMPLE_W-1:0]  adc_sample;

   modport source (output valid, operation, motor_id, target_angle, adc_sample,
                   input ready);
   modport sink   (input valid, operation, motor_id, target_angle, adc_sample,
                   output ready);
endinterface
`default_nettype wire

>>> src/spft_rsp_if.sv
// Response channel of the tracker: status, angle, PWM write and motion flags.
`default_nettype none
interface spft_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [spft_pkg::ANGLE_W-1:0]   angle_out;
   logic                           pwm_write;
   logic                           pwm_motor;
   logic [spft_pkg::COMPARE_W-1:0] pwm_compare;
   logic                           frame_done;
   logic [spft_pkg::FLAGS_W-1:0]   moving_flags;

   modport source (output valid, status, angle_out, pwm_write, pwm_motor, pwm_compare,
                   frame_done, moving_flags, input ready);
   modport sink   (input valid, status, angle_out, pwm_write, pwm_motor, pwm_compare,
                   frame_done, moving_flags, output ready);
endinterface
`default_nettype wire

>>> src/spft_csr_if.sv
// Configuration write channel of the tracker: register index and write data.
`default_nettype none
interface spft_csr_if;
   logic                               valid;
   logic                               ready;
   logic [spft_pkg::CSR_INDEX_W-1:0]   index;
   logic [7:0]                         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/spft_frame_angle.sv
// End-of-frame conversion of one motor's mean into an angle and its moving flag.
`default_nettype none
module spft_frame_angle #(
   parameter int unsigned MAX_ANGLE = 180,
   parameter int unsigned MAX_ADC   = 4095
) (
   input  wire logic [spft_pkg::MEAN_W-1:0]  mean,
   input  wire logic [spft_pkg::ANGLE_W-1:0] prev_angle,
   input  wire logic [spft_pkg::ANGLE_W-1:0] tolerance,
   output spft_pkg::frame_type               update
);

   // floor(MAX_ANGLE*v/MAX_ADC) is exact as (v*RCP) >> SHIFT, since v*MAX_ADC < 2**SHIFT.
   localparam int unsigned SHIFT = 24;
   localparam int unsigned PROD_W = spft_pkg::SAMPLE_W + 32;
   localparam logic [31:0] ANG_RCP =
      32'(((64'(MAX_ANGLE) << SHIFT) + 64'(MAX_ADC) - 64'd1) / 64'(MAX_ADC));

   logic [spft_pkg::SAMPLE_W-1:0] clamped;
   logic [PROD_W-1:0]             product;
   logic [spft_pkg::ANGLE_W-1:0]  angle;

   // Clamp the mean to full scale, then scale it to degrees.
   always_comb begin
      clamped = (mean < spft_pkg::MEAN_W'(MAX_ADC)) ? mean[spft_pkg::SAMPLE_W-1:0]
                                                    : spft_pkg::SAMPLE_W'(MAX_ADC);
      product = PROD_W'(clamped) * PROD_W'(ANG_RCP);
      angle   = product[SHIFT +: spft_pkg::ANGLE_W];
   end

   // The motor counts as moving when the angle moved by more than its tolerance.
   assign update.angle  = angle;
   assign update.moving = spft_pkg::exceeds(angle, prev_angle, tolerance);

endmodule
`default_nettype wire

>>> src/servo_position_feedback_tracker_unit.sv
// Top level of the servo position feedback tracker.
//
//   Channel | Direction | Carries
//   req_if  | in        | operation, motor_id, target_angle, adc_sample
//   rsp_if  | out       | status, angle_out, pwm_write, pwm_motor, pwm_compare,
//           |           | frame_done, moving_flags
//   csr_if  | in        | index, data (tolerance registers), always ready
//
// Every request gives exactly one response. The sample is divided and the compare value
// is looked up as the request is loaded into the input register; the state update then
// loads the response register. A new request is taken in every cycle while the response
// side does not stall. Reset clears the angles, the moving flags, the means and the sample
// position, and sets both tolerances to three degrees. A stalled response holds the
// pipeline; the input register still takes a request while it is empty.
`default_nettype none
module servo_position_feedback_tracker_unit #(
   parameter int unsigned MOTORS    = 2,
   parameter int unsigned SAMPLES   = 8,
   parameter int unsigned MAX_ANGLE = 180,
   parameter int unsigned MAX_ADC   = 4095
) (
   input wire logic clock,
   input wire logic reset,
   spft_req_if.sink   req_if,
   spft_rsp_if.source rsp_if,
   spft_csr_if.sink   csr_if
);

   localparam int unsigned ANGLE_W   = spft_pkg::ANGLE_W;
   localparam int unsigned SAMPLE_W  = spft_pkg::SAMPLE_W;
   localparam int unsigned COMPARE_W = spft_pkg::COMPARE_W;
   localparam int unsigned MEAN_W    = spft_pkg::MEAN_W;
   localparam int unsigned FRAME_LEN = MOTORS * SAMPLES;
   localparam int unsigned POS_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
   localparam int unsigned MOT_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   // floor(sample/SAMPLES) is exact as (sample*RCP) >> SHIFT, since sample*SAMPLES < 2**SHIFT.
   localparam int unsigned SMP_SHIFT = 24;
   localparam int unsigned SMP_RCP_W = SMP_SHIFT + 1;
   localparam int unsigned SMP_PROD_W = SAMPLE_W + SMP_RCP_W;
   localparam logic [SMP_RCP_W-1:0] SMP_RCP =
      SMP_RCP_W'(((64'd1 << SMP_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   // Compare value for every target angle, worked out at elaboration.
   typedef logic [COMPARE_W-1:0] cmp_table_type [256];

   function automatic cmp_table_type build_cmp_table();
      cmp_table_type tbl;
      int unsigned   clamped;
      for (int i = 0; i < 256; i++) begin
         clamped = (i < MAX_ANGLE) ? i : MAX_ANGLE;
         tbl[i]  = COMPARE_W'(spft_pkg::PWM_SPAN + spft_pkg::PWM_FLOOR -
                   (spft_pkg::PWM_SPAN * clamped + MAX_ANGLE - 1) / MAX_ANGLE);
      end
      return tbl;
   endfunction

   localparam cmp_table_type CMP_TABLE = build_cmp_table();

   // Handshake control.
   logic req_xfer;
   logic b_go;
   logic a_valid_ff, a_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Input register.
   logic [1:0]            a_op_ff;
   logic [7:0]            a_id_ff;
   logic [ANGLE_W-1:0]    a_tgt_ff;
   logic [SAMPLE_W-1:0]   a_quot_ff;
   logic [COMPARE_W-1:0]  a_cmp_ff;
   logic [SMP_PROD_W-1:0] smp_prod;

   // Tracker state.
   logic [ANGLE_W-1:0] tol_first_ff, tol_second_ff;
   logic [ANGLE_W-1:0] angle_ff [MOTORS];
   logic [ANGLE_W-1:0] angle_in [MOTORS];
   logic [MEAN_W-1:0]  mean_ff  [MOTORS];
   logic [MEAN_W-1:0]  mean_in  [MOTORS];
   logic [MEAN_W-1:0]  mean_sum [MOTORS];
   logic [MOTORS-1:0]  moving_ff, moving_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   spft_pkg::frame_type frame_upd [MOTORS];

   // Response register.
   logic                         rsp_status_ff, rsp_status_in;
   logic [ANGLE_W-1:0]           rsp_angle_ff, rsp_angle_in;
   logic                         rsp_pwm_write_ff, rsp_pwm_write_in;
   logic                         rsp_pwm_motor_ff, rsp_pwm_motor_in;
   logic [COMPARE_W-1:0]         rsp_compare_ff, rsp_compare_in;
   logic                         rsp_frame_ff, rsp_frame_in;
   logic [spft_pkg::FLAGS_W-1:0] rsp_flags_ff, rsp_flags_in;

   logic                sample_motor;
   logic [MOT_W-1:0]    cur_motor;
   logic [MOT_W-1:0]    id_idx;
   logic                id_valid;
   logic [ANGLE_W-1:0]  id_tol;

   // Transfers advance whenever the response register is free or being emptied.
   assign b_go          = a_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !a_valid_ff || b_go;
   assign req_xfer      = req_if.valid && req_if.ready;
   assign a_valid_in    = req_xfer ? 1'b1 : (b_go ? 1'b0 : a_valid_ff);
   assign rsp_valid_in  = b_go ? 1'b1 : (rsp_valid_ff && !rsp_if.ready);
   assign csr_if.ready  = 1'b1;

   // Divide the incoming sample by the frame length per motor.
   assign smp_prod = SMP_PROD_W'(req_if.adc_sample) * SMP_PROD_W'(SMP_RCP);

   // Motor of the next sample in the interleaved order.
   assign sample_motor = (MOTORS > 1) ? pos_ff[0] : 1'b0;
   assign cur_motor    = MOT_W'(sample_motor);

   // Addressed motor of a set or get request.
   assign id_valid = a_id_ff < 8'(MOTORS);
   assign id_idx   = a_id_ff[MOT_W-1:0];
   assign id_tol   = (id_idx == '0) ? tol_first_ff : tol_second_ff;

   // Means after the current sample, and the frame update of each motor.
   for (genvar k = 0; k < MOTORS; k++) begin : g_motor
      assign mean_sum[k] = (cur_motor == MOT_W'(k)) ? (mean_ff[k] + MEAN_W'(a_quot_ff))
                                                    : mean_ff[k];

      spft_frame_angle #(
         .MAX_ANGLE (MAX_ANGLE),
         .MAX_ADC   (MAX_ADC)
      ) u_frame_angle (
         .mean       (mean_sum[k]),
         .prev_angle (angle_ff[k]),
         .tolerance  ((k == 0) ? tol_first_ff : tol_second_ff),
         .update     (frame_upd[k])
      );
   end

   // State update and response for the request in the input register.
   always_comb begin
      angle_in         = angle_ff;
      mean_in          = mean_ff;
      moving_in        = moving_ff;
      pos_in           = pos_ff;
      rsp_status_in    = spft_pkg::STATUS_OK;
      rsp_angle_in     = '0;
      rsp_pwm_write_in = 1'b0;
      rsp_pwm_motor_in = 1'b0;
      rsp_compare_in   = '0;
      rsp_frame_in     = 1'b0;
      rsp_flags_in     = '0;
      if (b_go) begin
         unique case (a_op_ff) inside
            spft_pkg::OP_SAMPLE: begin
               mean_in = mean_sum;
               if (pos_ff == POS_W'(FRAME_LEN - 1)) begin
                  pos_in       = '0;
                  rsp_frame_in = 1'b1;
                  for (int k = 0; k < MOTORS; k++) begin
                     angle_in[k]  = frame_upd[k].angle;
                     moving_in[k] = frame_upd[k].moving;
                     mean_in[k]   = '0;
                  end
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            spft_pkg::OP_SET, spft_pkg::OP_GET: begin
               if (!id_valid) begin
                  rsp_status_in = spft_pkg::STATUS_BAD_MOTOR;
               end else if (a_op_ff == spft_pkg::OP_GET) begin
                  rsp_angle_in = angle_ff[id_idx];
               end else if (spft_pkg::exceeds(a_tgt_ff, angle_ff[id_idx], id_tol)) begin
                  rsp_pwm_write_in  = 1'b1;
                  rsp_pwm_motor_in  = a_id_ff[0];
                  rsp_compare_in    = a_cmp_ff;
                  moving_in[id_idx] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      for (int k = 0; k < MOTORS; k++) begin
         rsp_flags_in[k] = moving_in[k];
      end
   end

   // Control and tracker state.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tol_first_ff  <= spft_pkg::TOL_RESET;
         tol_second_ff <= spft_pkg::TOL_RESET;
         moving_ff     <= '0;
         pos_ff        <= '0;
         for (int k = 0; k < MOTORS; k++) begin
            angle_ff[k] <= '0;
            mean_ff[k]  <= '0;
         end
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         moving_ff    <= moving_in;
         pos_ff       <= pos_in;
         angle_ff     <= angle_in;
         mean_ff      <= mean_in;
         if (csr_if.valid) begin
            unique case (csr_if.index)
               spft_pkg::CSR_TOL_FIRST:  tol_first_ff  <= csr_if.data;
               spft_pkg::CSR_TOL_SECOND: tol_second_ff <= csr_if.data;
               default: begin
               end
            endcase
         end
      end
   end

   // Input register payload, with the quotient and compare value prepared.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_op_ff   <= req_if.operation;
         a_id_ff   <= req_if.motor_id;
         a_tgt_ff  <= req_if.target_angle;
         a_quot_ff <= smp_prod[SMP_SHIFT +: SAMPLE_W];
         a_cmp_ff  <= CMP_TABLE[req_if.target_angle];
      end
   end

   // Response register payload.
   always_ff @(posedge clock) begin
      if (b_go) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_angle_ff     <= rsp_angle_in;
         rsp_pwm_write_ff <= rsp_pwm_write_in;
         rsp_pwm_motor_ff <= rsp_pwm_motor_in;
         rsp_compare_ff   <= rsp_compare_in;
         rsp_frame_ff     <= rsp_frame_in;
         rsp_flags_ff     <= rsp_flags_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.angle_out    = rsp_angle_ff;
   assign rsp_if.pwm_write    = rsp_pwm_write_ff;
   assign rsp_if.pwm_motor    = rsp_pwm_motor_ff;
   assign rsp_if.pwm_compare  = rsp_compare_ff;
   assign rsp_if.frame_done   = rsp_frame_ff;
   assign rsp_if.moving_flags = rsp_flags_ff;

endmodule
`default_nettype wire

>>> bench/spft_scoreboard_pkg.sv
// Response prediction and checking for the servo position feedback tracker bench.
package spft_scoreboard_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import spft_pkg::*;

   // Build settings of the block under test (its parameter defaults).
   localparam int unsigned MOTOR_COUNT   = 2;
   localparam int unsigned FRAME_SAMPLES = 8;
   localparam int unsigned FULL_ANGLE    = 180;
   localparam int unsigned FULL_SCALE    = 4095;

   // One request transfer.
   typedef struct packed {
      logic [1:0]          operation;
      logic [7:0]          motor_id;
      logic [ANGLE_W-1:0]  target_angle;
      logic [SAMPLE_W-1:0] adc_sample;
   } tracker_request_t;

   // One response transfer.
   typedef struct packed {
      logic                 status;
      logic [ANGLE_W-1:0]   angle_out;
      logic                 pwm_write;
      logic                 pwm_motor;
      logic [COMPARE_W-1:0] pwm_compare;
      logic                 frame_done;
      logic [FLAGS_W-1:0]   moving_flags;
   } tracker_result_t;

   class tracker_scoreboard;
      logic [ANGLE_W-1:0] tolerance [MOTOR_COUNT];
      logic [ANGLE_W-1:0] angle [MOTOR_COUNT];
      logic               moving [MOTOR_COUNT];
      logic [MEAN_W-1:0]  mean [MOTOR_COUNT];
      int unsigned        position;
      tracker_result_t    awaited_responses [$];
      int unsigned        mismatches;

      function new();
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            tolerance[m] = TOL_RESET;
            angle[m]     = '0;
            moving[m]    = 1'b0;
            mean[m]      = '0;
         end
         position   = 0;
         mismatches = 0;
      endfunction

      // A write to an index beyond the register list changes nothing.
      function void set_tolerance(logic [CSR_INDEX_W-1:0] index, logic [7:0] data);
         if (index == CSR_TOL_FIRST) begin
            tolerance[0] = data;
         end else if (index == CSR_TOL_SECOND) begin
            tolerance[1] = data;
         end
      endfunction

      function int unsigned outstanding();
         return awaited_responses.size();
      endfunction

      function int unsigned angle_of(int unsigned m);
         return angle[m];
      endfunction

      function bit differs(int unsigned a, int unsigned b, int unsigned tol);
         int unsigned gap;
         gap = (a > b) ? a - b : b - a;
         return gap > tol;
      endfunction

      // Mean of a frame scaled to degrees, rounded down.
      function int unsigned angle_from_mean(int unsigned mean_value);
         int unsigned clipped;
         clipped = (mean_value < FULL_SCALE) ? mean_value : FULL_SCALE;
         return (FULL_ANGLE * clipped) / FULL_SCALE;
      endfunction

      // Coarse compare value for a target, with the span rounded up.
      function int unsigned compare_for(int unsigned target);
         int unsigned clipped;
         clipped = (target < FULL_ANGLE) ? target : FULL_ANGLE;
         return PWM_SPAN + PWM_FLOOR - (PWM_SPAN * clipped + FULL_ANGLE - 1) / FULL_ANGLE;
      endfunction

      // Advances the tracked state by one accepted request and queues its response.
      function void note_request(tracker_request_t r);
         tracker_result_t expected;
         int unsigned     m;
         int unsigned     previous;
         expected = '0;
         case (r.operation)
            OP_SAMPLE: begin
               m = position % MOTOR_COUNT;
               mean[m] = mean[m] + MEAN_W'(r.adc_sample / FRAME_SAMPLES);
               position++;
               // The last sample of a frame refreshes every angle and flag.
               if (position >= MOTOR_COUNT * FRAME_SAMPLES) begin
                  position = 0;
                  expected.frame_done = 1'b1;
                  for (int k = 0; k < MOTOR_COUNT; k++) begin
                     previous  = angle[k];
                     angle[k]  = ANGLE_W'(angle_from_mean(mean[k]));
                     moving[k] = differs(angle[k], previous, tolerance[k]);
                     mean[k]   = '0;
                  end
               end
            end
            OP_SET, OP_GET: begin
               if (r.motor_id >= MOTOR_COUNT) begin
                  expected.status = STATUS_BAD_MOTOR;
               end else if (r.operation == OP_GET) begin
                  expected.angle_out = angle[r.motor_id];
               end else if (differs(r.target_angle, angle[r.motor_id],
                                    tolerance[r.motor_id])) begin
                  expected.pwm_write   = 1'b1;
                  expected.pwm_motor   = r.motor_id[0];
                  expected.pwm_compare = COMPARE_W'(compare_for(r.target_angle));
                  moving[r.motor_id]   = 1'b1;
               end
            end
            default: begin
            end
         endcase
         expected.moving_flags = {moving[1], moving[0]};
         awaited_responses.push_back(expected);
      endfunction

      function void field_check(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Compares one response transfer with the oldest awaited one.
      function void check_response(tracker_result_t got);
         tracker_result_t want;
         if (awaited_responses.size() == 0) begin
            $display("%0t ns: response with none awaited, expected nothing, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = awaited_responses.pop_front();
         field_check("status", want.status, got.status);
         field_check("angle_out", want.angle_out, got.angle_out);
         field_check("pwm_write", want.pwm_write, got.pwm_write);
         field_check("pwm_motor", want.pwm_motor, got.pwm_motor);
         field_check("pwm_compare", want.pwm_compare, got.pwm_compare);
         field_check("frame_done", want.frame_done, got.frame_done);
         field_check("moving_flags", want.moving_flags, got.moving_flags);
      endfunction
   endclass

endpackage

>>> bench/testbench.sv
// Stimulus, handshake drivers and checking of the servo position feedback tracker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spft_pkg::*;
   import spft_scoreboard_pkg::*;

   // Codes the block has no meaning for.
   localparam logic [1:0]             OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 4'd9;

   localparam int unsigned PHASE_ITEMS  = 240;
   localparam int unsigned PHASE_COUNT  = 6;
   localparam int unsigned QUIET_PHASE  = 3;
   localparam int unsigned IDLE_PERCENT = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;

   tracker_scoreboard tracker;
   int unsigned       samples_sent = 0;
   int unsigned       level [MOTOR_COUNT];

   spft_req_if req_if ();
   spft_rsp_if rsp_if ();
   spft_csr_if csr_if ();

   servo_position_feedback_tracker_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #1 clock = ~clock;

   // The response side stalls now and then, except during the quiet phase.
   always @(negedge clock) begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Every response transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_response('{status: rsp_if.status, angle_out: rsp_if.angle_out,
                                  pwm_write: rsp_if.pwm_write, pwm_motor: rsp_if.pwm_motor,
                                  pwm_compare: rsp_if.pwm_compare,
                                  frame_done: rsp_if.frame_done,
                                  moving_flags: rsp_if.moving_flags});
      end
   end

   // Offers one request, with an occasional gap first, and notes it once transferred.
   task automatic send(logic [1:0] op, logic [7:0] id, logic [ANGLE_W-1:0] target,
                       logic [SAMPLE_W-1:0] sample);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.operation    <= op;
      req_if.motor_id     <= id;
      req_if.target_angle <= target;
      req_if.adc_sample   <= sample;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_request('{op, id, target, sample});
      if (op == OP_SAMPLE) begin
         samples_sent++;
      end
   endtask

   // Stops offering requests and waits for every awaited response.
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [7:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      tracker.set_tolerance(index, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly samples around a per-motor level so that frames move the angles, with
   // targets near the tracked angle to reach the tolerance boundary.
   task automatic send_random();
      int unsigned pick;
      int unsigned m;
      int          near;
      pick = $urandom_range(99);
      if (pick < 70) begin
         m = samples_sent % MOTOR_COUNT;
         if (samples_sent % (MOTOR_COUNT * FRAME_SAMPLES) == 0 && $urandom_range(1) == 1) begin
            level[0] = $urandom_range(4095);
            level[1] = $urandom_range(4095);
         end
         if ($urandom_range(4) == 0) begin
            near = $urandom_range(4095);
         end else begin
            near = int'(level[m]) + int'($urandom_range(128)) - 64;
            near = (near < 0) ? 0 : (near > 4095) ? 4095 : near;
         end
         send(OP_SAMPLE, 8'($urandom_range(255)), 8'($urandom_range(255)), 12'(near));
      end else if (pick < 80) begin
         m = $urandom_range(1);
         if ($urandom_range(1) == 1) begin
            near = int'(tracker.angle_of(m)) + int'($urandom_range(8)) - 4;
            near = (near < 0) ? 0 : (near > 255) ? 255 : near;
         end else begin
            near = $urandom_range(255);
         end
         send(OP_SET, 8'(m), 8'(near), 12'($urandom_range(4095)));
      end else if (pick < 90) begin
         send(OP_GET, 8'($urandom_range(1)), 8'($urandom_range(255)),
              12'($urandom_range(4095)));
      end else if (pick < 95) begin
         send(($urandom_range(1) == 1) ? OP_SET : OP_GET, 8'($urandom_range(255)),
              8'($urandom_range(255)), 12'($urandom_range(4095)));
      end else begin
         send(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
              12'($urandom_range(4095)));
      end
   endtask

   initial begin
      logic [7:0] first_tolerance [PHASE_COUNT];
      logic [7:0] second_tolerance [PHASE_COUNT];
      tracker = new();
      level[0] = 2048;
      level[1] = 1024;
      req_if.valid        = 1'b0;
      req_if.operation    = OP_SAMPLE;
      req_if.motor_id     = '0;
      req_if.target_angle = '0;
      req_if.adc_sample   = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = CSR_TOL_FIRST;
      csr_if.data         = '0;
      first_tolerance  = '{8'd0, 8'd255, 8'($urandom_range(255)), 8'd0, 8'd255,
                           8'($urandom_range(8))};
      second_tolerance = '{8'd255, 8'd0, 8'($urandom_range(255)), 8'd0, 8'd255,
                           8'($urandom_range(8))};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset tolerances: invalid motors, the unused code,
      // targets inside and beyond the tolerance, clipped targets and one full frame.
      send(OP_GET, 8'd0, 8'd0, 12'd0);
      send(OP_GET, 8'd2, 8'd0, 12'd0);
      send(OP_SET, 8'd255, 8'd90, 12'd0);
      send(OP_UNUSED, 8'd255, 8'd255, 12'hFFF);
      send(OP_SET, 8'd0, 8'd0, 12'd0);
      send(OP_SET, 8'd0, 8'd255, 12'd0);
      send(OP_SET, 8'd1, 8'd4, 12'd0);
      send(OP_SET, 8'd1, 8'd3, 12'd0);
      for (int i = 0; i < MOTOR_COUNT * FRAME_SAMPLES; i++) begin
         send(OP_SAMPLE, 8'd0, 8'd0, (i % 2 == 0) ? 12'hFFF : 12'h000);
      end
      send(OP_GET, 8'd0, 8'd0, 12'd0);
      drain();

      // Random phases, each under its own pair of tolerances.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(CSR_TOL_FIRST, first_tolerance[p]);
         write_register(CSR_TOL_SECOND, second_tolerance[p]);
         if (p == 2) begin
            write_register(CSR_UNUSED, 8'($urandom_range(255)));
         end
         quiet = (p == QUIET_PHASE);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random();
         end
         drain();
      end
      quiet = 1'b0;

      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
